// ----- hdl/socf_pkg.sv -----
// ---------------------------------------------------------------------------
// socf_pkg
// Shared types and codes for the segment cluster outlier filter.
// ---------------------------------------------------------------------------
package socf_pkg;

  // Command codes on the input channel
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  // Configuration register indexes
  localparam logic REG_NEAR_LIMIT     = 1'b0;
  localparam logic REG_PARALLEL_LIMIT = 1'b1;

  localparam int LIMIT_BITS = 24;
  localparam logic [LIMIT_BITS-1:0] NEAR_LIMIT_RESET     = 24'd49;
  localparam logic [LIMIT_BITS-1:0] PARALLEL_LIMIT_RESET = 24'd144;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAIR,
    ST_DRAIN,
    ST_COUNT,
    ST_BEST,
    ST_EMIT,
    ST_TAIL
  } state_t;

  // Per-cycle controls shared by every cell of the ring
  typedef struct packed {
    logic rotate;
    logic load_en;
    logic init;
    logic merge_en;
    logic count_en;
  } cell_ctrl_t;

endpackage

// ----- hdl/segment_cluster_outlier_filter.sv -----
// ---------------------------------------------------------------------------
// segment_cluster_outlier_filter
// Loads segments into a rotating ring of cells, links pairs through one
// pipelined tester, merges group labels across the ring, counts group sizes
// and flags the members of the largest group.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------------
//   in       | in        | in_valid / in_stall  | command, x_start..y_end
//   out      | out       | out_valid / out_stall| line_index, keep, last
//   cfg      | in        | cfg_we               | cfg_index, cfg_data
//
// Loads may follow back to back.
// A run tests the segment pairs while the ring turns (one tester pipeline),
// drains the tester, counts the group sizes, picks the largest group and
// emits the results.
// Input is stalled for the whole run; output stalls hold the ring still.
// Reset is synchronous and leaves the store empty; no clearing pass is needed.
// ---------------------------------------------------------------------------
module segment_cluster_outlier_filter #(
  parameter int MAX_LINES  = 64,
  parameter int COORD_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           command,
  input  logic [COORD_BITS-1:0]          x_start,
  input  logic [COORD_BITS-1:0]          y_start,
  input  logic [COORD_BITS-1:0]          x_end,
  input  logic [COORD_BITS-1:0]          y_end,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [$clog2(MAX_LINES)-1:0]   line_index,
  output logic                           keep,
  output logic                           last,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [socf_pkg::LIMIT_BITS-1:0] cfg_data
);

  localparam int IW = $clog2(MAX_LINES);
  localparam int CW = $clog2(MAX_LINES + 1);
  localparam int SW = 4 * COORD_BITS;
  localparam logic [IW-1:0] LAST_POS = IW'(MAX_LINES - 1);

  // configuration registers
  logic [socf_pkg::LIMIT_BITS-1:0] near_limit_sq, parallel_near_limit_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_limit_sq          <= socf_pkg::NEAR_LIMIT_RESET;
      parallel_near_limit_sq <= socf_pkg::PARALLEL_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        socf_pkg::REG_NEAR_LIMIT:     near_limit_sq          <= cfg_data;
        socf_pkg::REG_PARALLEL_LIMIT: parallel_near_limit_sq <= cfg_data;
        default: ;
      endcase
    end
  end

  // ring of cells
  socf_pkg::cell_ctrl_t ctrl;
  logic [SW-1:0] c_seg   [MAX_LINES];
  logic [IW-1:0] c_idx   [MAX_LINES];
  logic [IW-1:0] c_label [MAX_LINES];
  logic [CW-1:0] c_count [MAX_LINES];
  logic [IW-1:0] merge_from, merge_to, count_label, load_idx;

  for (genvar k = 0; k < MAX_LINES; k++) begin : g_ring
    socf_cell #(.COORD_BITS(COORD_BITS), .IW(IW), .CW(CW)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .home_idx    (IW'(k)),
      .load_idx    (load_idx),
      .load_seg    ({x_start, y_start, x_end, y_end}),
      .merge_from  (merge_from),
      .merge_to    (merge_to),
      .count_label (count_label),
      .nb_seg      (c_seg[(k + 1) % MAX_LINES]),
      .nb_idx      (c_idx[(k + 1) % MAX_LINES]),
      .nb_label    (c_label[(k + 1) % MAX_LINES]),
      .nb_count    (c_count[(k + 1) % MAX_LINES]),
      .seg         (c_seg[k]),
      .idx         (c_idx[k]),
      .label       (c_label[k]),
      .count       (c_count[k])
    );
  end

  // sequencer registers
  socf_pkg::state_t state, state_next;
  logic [CW-1:0] n_loaded;
  logic [IW-1:0] step, pass;
  logic [SW-1:0] probe;
  logic [IW-1:0] best;
  logic [CW-1:0] best_cnt;

  logic in_xfer, run_xfer, load_xfer, slot_free, step_end, head_live;
  logic pair_valid;
  logic busy, link_valid, link;
  logic [IW-1:0] link_i, link_j;

  assign in_xfer   = in_valid && !in_stall;
  assign run_xfer  = in_xfer && (command == socf_pkg::CMD_RUN);
  assign load_xfer = in_xfer && (command == socf_pkg::CMD_LOAD);
  assign slot_free = !out_valid || !out_stall;
  assign step_end  = (step == LAST_POS);
  assign head_live = CW'(c_idx[0]) < n_loaded;
  assign in_stall  = (state != socf_pkg::ST_IDLE);

  // pair tester
  assign pair_valid = (state == socf_pkg::ST_PAIR) && (c_idx[0] > pass) && head_live;

  socf_pair_test #(.COORD_BITS(COORD_BITS), .IW(IW)) u_pair (
    .clk                    (clk),
    .rst                    (rst),
    .pair_valid             (pair_valid),
    .seg_a                  (probe),
    .seg_b                  (c_seg[0]),
    .pair_i                 (pass),
    .pair_j                 (c_idx[0]),
    .near_limit_sq          (near_limit_sq),
    .parallel_near_limit_sq (parallel_near_limit_sq),
    .busy                   (busy),
    .link_valid             (link_valid),
    .link                   (link),
    .link_i                 (link_i),
    .link_j                 (link_j)
  );

  // current labels of the linked pair, found by index match
  logic [IW-1:0] lab_i, lab_j;
  always_comb begin
    lab_i = '0;
    lab_j = '0;
    for (int k = 0; k < MAX_LINES; k++) begin
      lab_i = lab_i | ((c_idx[k] == link_i) ? c_label[k] : '0);
      lab_j = lab_j | ((c_idx[k] == link_j) ? c_label[k] : '0);
    end
    merge_from = (lab_i > lab_j) ? lab_i : lab_j;
    merge_to   = (lab_i > lab_j) ? lab_j : lab_i;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      socf_pkg::ST_IDLE: begin
        if (run_xfer && n_loaded >= CW'(2)) begin
          state_next = socf_pkg::ST_PAIR;
        end else if (run_xfer && n_loaded == CW'(1)) begin
          state_next = socf_pkg::ST_DRAIN;
        end
      end
      socf_pkg::ST_PAIR:
        if (step_end && (CW'(pass) + CW'(2) == n_loaded)) state_next = socf_pkg::ST_DRAIN;
      socf_pkg::ST_DRAIN:
        if (!busy) state_next = socf_pkg::ST_COUNT;
      socf_pkg::ST_COUNT:
        if (step_end) state_next = socf_pkg::ST_BEST;
      socf_pkg::ST_BEST:
        if (step_end) state_next = socf_pkg::ST_EMIT;
      socf_pkg::ST_EMIT: begin
        if (slot_free && CW'(c_idx[0]) + CW'(1) == n_loaded) begin
          state_next = step_end ? socf_pkg::ST_IDLE : socf_pkg::ST_TAIL;
        end
      end
      socf_pkg::ST_TAIL:
        if (step_end) state_next = socf_pkg::ST_IDLE;
      default: state_next = socf_pkg::ST_IDLE;
    endcase
  end

  // ring controls
  always_comb begin
    ctrl        = '0;
    load_idx    = n_loaded[IW-1:0];
    count_label = c_label[0];
    unique case (state)
      socf_pkg::ST_IDLE: begin
        ctrl.load_en = load_xfer && (n_loaded < CW'(MAX_LINES));
        ctrl.init    = run_xfer;
      end
      socf_pkg::ST_PAIR, socf_pkg::ST_BEST, socf_pkg::ST_TAIL:
        ctrl.rotate = 1'b1;
      socf_pkg::ST_DRAIN: ;
      socf_pkg::ST_COUNT: begin
        ctrl.rotate   = 1'b1;
        ctrl.count_en = head_live;
      end
      socf_pkg::ST_EMIT:
        ctrl.rotate = slot_free;
      default: ;
    endcase
    ctrl.merge_en = link_valid && link && (lab_i != lab_j);
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= socf_pkg::ST_IDLE;
      n_loaded <= '0;
      step     <= '0;
      pass     <= '0;
    end else begin
      state <= state_next;
      if (ctrl.load_en) n_loaded <= n_loaded + CW'(1);
      if (state != socf_pkg::ST_IDLE && state_next == socf_pkg::ST_IDLE) n_loaded <= '0;
      if (ctrl.rotate) step <= step_end ? '0 : step + IW'(1);
      if (run_xfer) begin
        step <= '0;
        pass <= '0;
      end else if (state == socf_pkg::ST_PAIR && step_end) begin
        pass <= pass + IW'(1);
      end
    end
  end

  // probe capture and largest-group search
  always_ff @(posedge clk) begin
    if (state == socf_pkg::ST_PAIR && c_idx[0] == pass) probe <= c_seg[0];
    if (state == socf_pkg::ST_COUNT) begin
      best     <= '0;
      best_cnt <= '0;
    end else if (state == socf_pkg::ST_BEST && head_live && c_count[0] > best_cnt) begin
      best     <= c_idx[0];
      best_cnt <= c_count[0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == socf_pkg::ST_EMIT && slot_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == socf_pkg::ST_EMIT && slot_free) begin
      line_index <= c_idx[0];
      keep       <= (c_label[0] == best);
      last       <= (CW'(c_idx[0]) + CW'(1) == n_loaded);
    end
  end

endmodule

// ----- hdl/socf_cell.sv -----
// ---------------------------------------------------------------------------
// socf_cell
// One ring cell: holds a segment, its load index, its group label and a
// member count. Takes its neighbour's contents when the ring rotates.
// ---------------------------------------------------------------------------
module socf_cell #(
  parameter int COORD_BITS = 12,
  parameter int IW         = 6,
  parameter int CW         = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  socf_pkg::cell_ctrl_t    ctrl,
  input  logic [IW-1:0]           home_idx,
  input  logic [IW-1:0]           load_idx,
  input  logic [4*COORD_BITS-1:0] load_seg,
  input  logic [IW-1:0]           merge_from,
  input  logic [IW-1:0]           merge_to,
  input  logic [IW-1:0]           count_label,
  input  logic [4*COORD_BITS-1:0] nb_seg,
  input  logic [IW-1:0]           nb_idx,
  input  logic [IW-1:0]           nb_label,
  input  logic [CW-1:0]           nb_count,
  output logic [4*COORD_BITS-1:0] seg,
  output logic [IW-1:0]           idx,
  output logic [IW-1:0]           label,
  output logic [CW-1:0]           count
);

  logic [4*COORD_BITS-1:0] src_seg;
  logic [IW-1:0]           src_idx;
  logic [IW-1:0]           src_label;
  logic [CW-1:0]           src_count;
  logic [4*COORD_BITS-1:0] seg_next;
  logic [IW-1:0]           label_next;
  logic [CW-1:0]           count_next;

  // source: own contents or the neighbour's on a rotate
  always_comb begin
    src_seg   = ctrl.rotate ? nb_seg   : seg;
    src_idx   = ctrl.rotate ? nb_idx   : idx;
    src_label = ctrl.rotate ? nb_label : label;
    src_count = ctrl.rotate ? nb_count : count;
  end

  // load, relabel and count updates on the travelling contents
  always_comb begin
    seg_next = (ctrl.load_en && src_idx == load_idx) ? load_seg : src_seg;
    if (ctrl.init) begin
      label_next = src_idx;
    end else if (ctrl.merge_en && src_label == merge_from) begin
      label_next = merge_to;
    end else begin
      label_next = src_label;
    end
    if (ctrl.init) begin
      count_next = '0;
    end else if (ctrl.count_en && src_idx == count_label) begin
      count_next = src_count + CW'(1);
    end else begin
      count_next = src_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= home_idx;
    end else begin
      idx <= src_idx;
    end
  end

  always_ff @(posedge clk) begin
    seg   <= seg_next;
    label <= label_next;
    count <= count_next;
  end

endmodule

// ----- hdl/socf_pair_test.sv -----
// ---------------------------------------------------------------------------
// socf_pair_test
// Three-stage link test for one segment pair: crossing by orientation,
// squared endpoint distances, and the near-parallel slope range.
// ---------------------------------------------------------------------------
module socf_pair_test #(
  parameter int COORD_BITS = 12,
  parameter int IW         = 6
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    pair_valid,
  input  logic [4*COORD_BITS-1:0] seg_a,
  input  logic [4*COORD_BITS-1:0] seg_b,
  input  logic [IW-1:0]           pair_i,
  input  logic [IW-1:0]           pair_j,
  input  logic [socf_pkg::LIMIT_BITS-1:0] near_limit_sq,
  input  logic [socf_pkg::LIMIT_BITS-1:0] parallel_near_limit_sq,
  output logic                    busy,
  output logic                    link_valid,
  output logic                    link,
  output logic [IW-1:0]           link_i,
  output logic [IW-1:0]           link_j
);

  localparam int C  = COORD_BITS;
  localparam int DF = C + 1;          // coordinate difference
  localparam int SL = C + 2;          // slope numerator / denominator
  localparam int PW = 2 * DF;         // orientation product
  localparam int OW = PW + 1;         // orientation value
  localparam int SQ = 2 * C + 2;      // squared distance sum
  localparam int DW = (SQ > socf_pkg::LIMIT_BITS) ? SQ : socf_pkg::LIMIT_BITS;
  localparam int MW = 2 * SL;         // slope cross product
  localparam int RW = MW + 4;         // scaled slope product

  // unpack
  logic [C-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  assign {ax0, ay0, ax1, ay1} = seg_a;
  assign {bx0, by0, bx1, by1} = seg_b;

  function automatic logic signed [DF-1:0] sub(input logic [C-1:0] p, input logic [C-1:0] q);
    sub = $signed({1'b0, p}) - $signed({1'b0, q});
  endfunction

  function automatic logic inbox(input logic [C-1:0] x0, input logic [C-1:0] y0,
                                 input logic [C-1:0] x1, input logic [C-1:0] y1,
                                 input logic [C-1:0] px, input logic [C-1:0] py);
    logic [C-1:0] lx, hx, ly, hy;
    lx = (x0 < x1) ? x0 : x1;
    hx = (x0 < x1) ? x1 : x0;
    ly = (y0 < y1) ? y0 : y1;
    hy = (y0 < y1) ? y1 : y0;
    inbox = (px >= lx) && (px <= hx) && (py >= ly) && (py <= hy);
  endfunction

  // ---- stage 1: differences, slopes, bounding-box tests
  logic signed [SL-1:0] sn1_c, sq1_c, sn2_c, sq2_c;
  logic signed [SL-1:0] dxa_c, dxb_c;

  always_comb begin
    dxa_c = $signed({2'b0, ax0}) + ((ax0 == ax1) ? SL'(1) : SL'(0)) - $signed({2'b0, ax1});
    dxb_c = $signed({2'b0, bx0}) + ((bx0 == bx1) ? SL'(1) : SL'(0)) - $signed({2'b0, bx1});
    sn1_c = SL'(sub(ay0, ay1));
    sn2_c = SL'(sub(by0, by1));
    sq1_c = dxa_c;
    sq2_c = dxb_c;
    if (dxa_c < 0) begin
      sn1_c = -sn1_c;
      sq1_c = -dxa_c;
    end
    if (dxb_c < 0) begin
      sn2_c = -sn2_c;
      sq2_c = -dxb_c;
    end
  end

  logic               v1;
  logic [IW-1:0]      i1, j1;
  logic signed [DF-1:0] dax, day, dbx, dby, u0x, u0y, u1x, u1y, v0x, v0y, v1x, v1y, wx, wy;
  logic signed [SL-1:0] n1, q1, n2, q2;
  logic [3:0]         box1;

  always_ff @(posedge clk) begin
    dax <= sub(ax1, ax0);  day <= sub(ay1, ay0);
    dbx <= sub(bx1, bx0);  dby <= sub(by1, by0);
    u0x <= sub(bx0, ax0);  u0y <= sub(by0, ay0);
    u1x <= sub(bx1, ax0);  u1y <= sub(by1, ay0);
    v0x <= sub(ax0, bx0);  v0y <= sub(ay0, by0);
    v1x <= sub(ax1, bx0);  v1y <= sub(ay1, by0);
    wx  <= sub(ax1, bx1);  wy  <= sub(ay1, by1);
    n1 <= sn1_c;  q1 <= sq1_c;  n2 <= sn2_c;  q2 <= sq2_c;
    box1 <= {inbox(bx0, by0, bx1, by1, ax1, ay1),
             inbox(bx0, by0, bx1, by1, ax0, ay0),
             inbox(ax0, ay0, ax1, ay1, bx1, by1),
             inbox(ax0, ay0, ax1, ay1, bx0, by0)};
    i1 <= pair_i;
    j1 <= pair_j;
  end

  // ---- stage 2: products
  logic               v2;
  logic [IW-1:0]      i2, j2;
  logic signed [PW-1:0] p1a, p1b, p2a, p2b, p3a, p3b, p4a, p4b;
  logic [SQ-1:0]      dd0, dd1, dd2, dd3;
  logic signed [MW-1:0] sp, sm;
  logic [3:0]         box2;

  always_ff @(posedge clk) begin
    p1a <= dax * u0y;  p1b <= day * u0x;
    p2a <= dax * u1y;  p2b <= day * u1x;
    p3a <= dbx * v0y;  p3b <= dby * v0x;
    p4a <= dbx * v1y;  p4b <= dby * v1x;
    dd0 <= SQ'($unsigned(PW'(v0x * v0x))) + SQ'($unsigned(PW'(v0y * v0y)));
    dd1 <= SQ'($unsigned(PW'((v0x + u0x - u1x) * (v0x + u0x - u1x))))
         + SQ'($unsigned(PW'((v0y + u0y - u1y) * (v0y + u0y - u1y))));
    dd2 <= SQ'($unsigned(PW'(v1x * v1x))) + SQ'($unsigned(PW'(v1y * v1y)));
    dd3 <= SQ'($unsigned(PW'(wx * wx))) + SQ'($unsigned(PW'(wy * wy)));
    sp  <= n1 * q2;
    sm  <= n2 * q1;
    box2 <= box1;
    i2 <= i1;
    j2 <= j1;
  end

  // ---- stage 3: orientations, distance and slope decisions
  logic signed [OW-1:0] o1, o2, o3, o4;
  logic signed [RW-1:0] lo_c, hi_c, mid_c;
  logic                 par_c;
  logic                 close_c;
  logic [DW-1:0]        lim_c;

  always_comb begin
    o1 = OW'(p1a) - OW'(p1b);
    o2 = OW'(p2a) - OW'(p2b);
    o3 = OW'(p3a) - OW'(p3b);
    o4 = OW'(p4a) - OW'(p4b);
    lo_c  = (RW'(sp) <<< 3) + RW'(sp);
    hi_c  = (RW'(sp) <<< 3) + (RW'(sp) <<< 1) + RW'(sp);
    mid_c = (RW'(sm) <<< 3) + (RW'(sm) <<< 1);
    if (sp < 0) begin
      par_c = (hi_c < mid_c) && (mid_c < lo_c);
    end else begin
      par_c = (lo_c < mid_c) && (mid_c < hi_c);
    end
    lim_c = par_c ? DW'(parallel_near_limit_sq) : DW'(near_limit_sq);
    close_c = (DW'(dd0) < lim_c) || (DW'(dd1) < lim_c) ||
              (DW'(dd2) < lim_c) || (DW'(dd3) < lim_c);
  end

  function automatic logic [1:0] sgn(input logic signed [OW-1:0] v);
    sgn = (v > 0) ? 2'b01 : ((v < 0) ? 2'b11 : 2'b00);
  endfunction

  logic          v3;
  logic [IW-1:0] i3, j3;
  logic [1:0]    s1, s2, s3, s4;
  logic          close3;
  logic [3:0]    box3;

  always_ff @(posedge clk) begin
    s1 <= sgn(o1);  s2 <= sgn(o2);  s3 <= sgn(o3);  s4 <= sgn(o4);
    close3 <= close_c;
    box3 <= box2;
    i3 <= i2;
    j3 <= j2;
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= pair_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // final link decision
  always_comb begin
    link = close3 ||
           ((s1 != s2) && (s3 != s4)) ||
           ((s1 == 2'b00) && box3[0]) ||
           ((s2 == 2'b00) && box3[1]) ||
           ((s3 == 2'b00) && box3[2]) ||
           ((s4 == 2'b00) && box3[3]);
  end

  assign link_valid = v3;
  assign link_i     = i3;
  assign link_j     = j3;
  assign busy       = v1 || v2 || v3;

endmodule
